[hdl/tch_pkg.sv]
package tch_pkg;

    typedef enum logic [1:0] {
        CMD_SPRITE = 2'd0,
        CMD_TILE   = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_FLUSH  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_MEM_FULL  = 3'd4,
        ST_FORMAT    = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_CHECK,
        S_ENTRY_WAIT,
        S_MUL,
        S_FIT,
        S_WRITE,
        S_DONE
    } state_t;

    localparam logic [0:0] REG_MEMORY_BASE = 1'd0;
    localparam logic [0:0] REG_MEMORY_SIZE = 1'd1;
    localparam logic [32:0] MEM_TOP_MAX = 33'h0_FFFF_FFC0;

endpackage

[hdl/texture_cache_hash_table_core.sv]
// Sequence: a command reads its bucket head, then compares chain entries one at a time;
// a miss on a sprite or tile command goes on to a fit check and an insert. A flush
// clears the bucket memory and then strobes its result.
// Flow: busy stays high through the strobe cycle, so a new transfer is taken only after
// the previous result; the receiver cannot stall results.
// Reset: a clearing pass empties the bucket memory, busy meanwhile; registers return
// to memory_base 0, memory_size 2097152.
module texture_cache_hash_table_core
    import tch_pkg::*;
#(
    parameter int CACHE_ENTRIES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [1:0]  cmd,
    input  logic [18:0] source_address,
    input  logic [15:0] mode_word,
    input  logic [15:0] colour_word,
    input  logic [2:0]  tile_format,
    input  logic [10:0] palette_base,
    input  logic [10:0] palette_offset,
    input  logic        transparent,
    input  logic [9:0]  width,
    input  logic [9:0]  height,
    input  logic [31:0] lookup_key,
    output logic        done,
    output logic [2:0]  status,
    output logic [31:0] key,
    output logic [31:0] texture_address
);

    localparam int AW = $clog2(CACHE_ENTRIES);
    localparam int LW = $clog2(CACHE_ENTRIES + 1);
    localparam logic [LW-1:0] ENTRIES_L = LW'(CACHE_ENTRIES);

    state_t state_reg, state_next;
    logic [31:0] base_reg;
    logic [22:0] size_reg;
    logic [31:0] key_reg, key_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic        fmt1_reg, fmt1_next;
    logic [10:0] mw_reg, mw_next;
    logic [9:0]  mh_reg, mh_next;
    logic [31:0] bytes_reg, bytes_next;
    logic [AW-1:0] hash_reg, hash_next;
    logic [LW-1:0] link_reg, link_next;
    logic [LW-1:0] used_reg, used_next;
    logic [31:0] free_reg, free_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [2:0]  st_reg, st_next;
    logic [31:0] oaddr_reg, oaddr_next;
    logic        done_reg, done_next;

    // bucket memory holds entry index + 1, zero for empty
    logic          hd_we, en_we;
    logic [AW-1:0] hd_waddr, hd_raddr, en_addr;
    logic [LW-1:0] hd_wdata, hd_rdata;
    logic [31:0]   ek_rdata, ea_rdata;
    logic [LW-1:0] ex_rdata;

    tch_ram #(.WIDTH(LW), .DEPTH(CACHE_ENTRIES)) u_head (
        .clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
        .raddr(hd_raddr), .rdata(hd_rdata));
    tch_ram #(.WIDTH(32), .DEPTH(CACHE_ENTRIES)) u_ekey (
        .clk(clk), .we(en_we), .waddr(en_addr), .wdata(key_reg),
        .raddr(en_addr), .rdata(ek_rdata));
    tch_ram #(.WIDTH(32), .DEPTH(CACHE_ENTRIES)) u_eaddr (
        .clk(clk), .we(en_we), .waddr(en_addr), .wdata(free_reg),
        .raddr(en_addr), .rdata(ea_rdata));
    tch_ram #(.WIDTH(LW), .DEPTH(CACHE_ENTRIES)) u_enext (
        .clk(clk), .we(en_we), .waddr(en_addr), .wdata(link_reg),
        .raddr(en_addr), .rdata(ex_rdata));

    logic [LW-1:0] idx;
    logic [32:0]   top, top_c, endv;
    logic [31:0]   end32, aligned;
    logic [20:0]   prod;
    logic [2:0]    sfmt;
    logic [AW-1:0] h_in;
    logic [31:0]   key_in;

    always_comb
    begin
        idx = link_reg - LW'(1);
        top = {1'b0, base_reg} + {10'd0, size_reg};
        top_c = (top > MEM_TOP_MAX) ? MEM_TOP_MAX : top;
        endv = {1'b0, free_reg} + {1'b0, bytes_reg};
        end32 = endv[31:0];
        aligned = (end32[5:0] != 6'd0) ? ({end32[31:6], 6'd0} + 32'h40) : end32;
        prod = mw_reg * mh_reg;
        sfmt = mode_word[5:3];
        case (cmd)
            CMD_SPRITE: key_in = {1'b1, mode_word[6:3], 11'd0, source_address[15:0]}
                | ((sfmt >= 3'd5) ? 32'd0 : {8'd0, colour_word[7:0], 16'd0});
            CMD_TILE: key_in = {1'b0, transparent, tile_format, 11'd0, source_address[18:3]}
                | ((tile_format >= 3'd3) ? 32'd0
                   : {5'd0, palette_base | palette_offset, 16'd0});
            default: key_in = lookup_key;
        endcase
        h_in = AW'(key_in % CACHE_ENTRIES);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            base_reg  <= 32'd0;
            size_reg  <= 23'd2097152;
            used_reg  <= '0;
            free_reg  <= 32'd0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            cmd_reg   <= CMD_SPRITE;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            free_reg  <= free_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            cmd_reg   <= cmd_next;
            if (cfg_we && cfg_index == REG_MEMORY_BASE)
            begin
                base_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_MEMORY_SIZE)
            begin
                size_reg <= cfg_data[22:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        fmt1_reg  <= fmt1_next;
        mw_reg    <= mw_next;
        mh_reg    <= mh_next;
        bytes_reg <= bytes_next;
        hash_reg  <= hash_next;
        link_reg  <= link_next;
        st_reg    <= st_next;
        oaddr_reg <= oaddr_next;
    end

    always_comb
    begin
        state_next = state_reg;
        key_next = key_reg;
        cmd_next = cmd_reg;
        fmt1_next = fmt1_reg;
        mw_next = mw_reg;
        mh_next = mh_reg;
        bytes_next = bytes_reg;
        hash_next = hash_reg;
        link_next = link_reg;
        used_next = used_reg;
        free_next = free_reg;
        clr_next = clr_reg;
        st_next = st_reg;
        oaddr_next = oaddr_reg;
        done_next = 1'b0;
        hd_we = 1'b0;
        hd_waddr = hash_reg;
        hd_wdata = '0;
        hd_raddr = hash_reg;
        en_we = 1'b0;
        en_addr = idx[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (start && !busy)
                begin
                    key_next = key_in;
                    cmd_next = cmd;
                    hash_next = h_in;
                    fmt1_next = (sfmt == 3'd1);
                    mw_next = (cmd == CMD_SPRITE) ? {1'b0, width}
                        : ({1'b0, width} + 11'd3) & 11'h7FC;
                    mh_next = height;
                    if (cmd == CMD_FLUSH)
                    begin
                        used_next = '0;
                        free_next = base_reg;
                        clr_next = '0;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_HEAD_RD;
                    end
                end
            end
            S_CLEAR:
            begin
                hd_we = 1'b1;
                hd_waddr = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(CACHE_ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                    // flush result; reset pass reports nothing
                    if (cmd_reg == CMD_FLUSH && used_reg == '0 && free_reg == base_reg
                        && st_reg == ST_HIT)
                    begin
                        done_next = 1'b1;
                    end
                    oaddr_next = 32'd0;
                    key_next = 32'd0;
                end
            end
            S_HEAD_RD:
            begin
                state_next = S_HEAD_WAIT;
                bytes_next = {9'd0, prod, 2'd0};
            end
            S_HEAD_WAIT:
            begin
                link_next = hd_rdata;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (link_reg == '0 || idx >= used_reg)
                begin
                    if (cmd_reg == CMD_LOOKUP)
                    begin
                        st_next = ST_NOT_FOUND;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FIT;
                    end
                    // keep chain head for the new entry's link
                    link_next = hd_rdata;
                end
                else
                begin
                    state_next = S_ENTRY_WAIT;
                end
            end
            S_ENTRY_WAIT:
            begin
                if (ek_rdata == key_reg)
                begin
                    st_next = ST_HIT;
                    oaddr_next = ea_rdata;
                    state_next = S_DONE;
                end
                else
                begin
                    link_next = ex_rdata;
                    state_next = S_CHECK;
                end
            end
            S_FIT:
            begin
                if (used_reg >= ENTRIES_L)
                begin
                    st_next = ST_TABLE_FULL;
                    state_next = S_DONE;
                end
                else if (endv > top_c)
                begin
                    st_next = ST_MEM_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                en_we = 1'b1;
                en_addr = used_reg[AW-1:0];
                hd_we = 1'b1;
                hd_wdata = used_reg + LW'(1);
                used_next = used_reg + LW'(1);
                oaddr_next = free_reg;
                free_next = aligned;
                st_next = (cmd_reg == CMD_SPRITE && fmt1_reg) ? ST_FORMAT : ST_INSERTED;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done_next = 1'b1;
                if (st_reg >= ST_NOT_FOUND)
                begin
                    key_next = 32'd0;
                end
                if (st_reg == ST_NOT_FOUND || st_reg == ST_TABLE_FULL
                    || st_reg == ST_MEM_FULL)
                begin
                    oaddr_next = 32'd0;
                end
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_IDLE && start && !busy && cmd == CMD_FLUSH)
        begin
            st_next = ST_HIT;
        end
        if (state_reg == S_HEAD_RD)
        begin
            link_next = '0;
        end
    end

    // head read data stays valid through the walk since hd_raddr holds hash_reg
    assign busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;
    assign status = st_reg;
    assign key = key_reg;
    assign texture_address = oaddr_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= ENTRIES_L) else $error("entry count overflow");
    a_free_align: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WRITE |=> free_reg[5:0] == 6'd0) else $error("free pointer unaligned");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE) else $error("result while busy");
    a_err_key: assert property (@(posedge clk) disable iff (!rst_n)
        done && status >= ST_NOT_FOUND |-> key == 32'd0) else $error("key on error");

endmodule

[hdl/tch_ram.sv]
module tch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
